FILE: src/five_bit_to_prefix_code_transcoder_top_assert.svh
// Assertion macros for the prefix code transcoder.
// Used inside modules that have clk and an active-low rst_n in scope.
`ifndef FIVE_BIT_TO_PREFIX_CODE_TRANSCODER_TOP_ASSERT_SVH
`define FIVE_BIT_TO_PREFIX_CODE_TRANSCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pct_pkg.sv
// Shared types, code table and lookup functions for the prefix code transcoder.
// No dependencies.
`timescale 1ns / 1ps

package pct_pkg;

  localparam int SYM_BITS = 5;   // bits per mapped symbol
  localparam int PEND_W   = 7;   // pending buffer width
  localparam int CNT_W    = 3;   // pending bit count width
  localparam int CODE_N   = 32;  // codewords in the table
  localparam int CODE_W   = 8;   // longest codeword

  typedef struct packed {
    logic [7:0] char_in;
    logic       char_valid;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       is_line_end;
    logic       last;
  } out_item_t;

  // Decoder step control and match result.
  typedef struct packed {
    logic step;
    logic bit_in;
    logic clear;
  } dec_ctl_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } dec_res_t;

  typedef struct packed {
    logic                known;
    logic [SYM_BITS-1:0] idx;
  } sym_t;

  typedef struct packed {
    logic [CODE_W-1:0] value;
    logic [3:0]        len;
    logic [7:0]        ch;
  } code_t;

  localparam code_t CODE_TABLE [CODE_N] = '{
    '{8'h05, 4'd3, 8'h20}, '{8'h06, 4'd3, 8'h45}, '{8'h07, 4'd3, 8'h50},
    '{8'h05, 4'd4, 8'h43}, '{8'h01, 4'd4, 8'h44}, '{8'h07, 4'd4, 8'h49},
    '{8'h06, 4'd4, 8'h4B}, '{8'h08, 4'd4, 8'h52},
    '{8'h09, 4'd5, 8'h46}, '{8'h04, 4'd5, 8'h4C}, '{8'h05, 4'd5, 8'h4F},
    '{8'h06, 4'd5, 8'h53}, '{8'h07, 4'd5, 8'h54},
    '{8'h00, 4'd6, 8'h27}, '{8'h03, 4'd6, 8'h2C}, '{8'h11, 4'd6, 8'h2E},
    '{8'h01, 4'd6, 8'h3F}, '{8'h25, 4'd6, 8'h41}, '{8'h10, 4'd6, 8'h48},
    '{8'h02, 4'd6, 8'h57},
    '{8'h91, 4'd8, 8'h2D}, '{8'h9A, 4'd8, 8'h42}, '{8'h9B, 4'd8, 8'h47},
    '{8'h98, 4'd8, 8'h4A}, '{8'h99, 4'd8, 8'h4D}, '{8'h9E, 4'd8, 8'h4E},
    '{8'h9F, 4'd8, 8'h51}, '{8'h9C, 4'd8, 8'h55}, '{8'h9D, 4'd8, 8'h56},
    '{8'h92, 4'd8, 8'h58}, '{8'h93, 4'd8, 8'h59}, '{8'h90, 4'd8, 8'h5A}
  };

  // Byte to 5-bit symbol index; alphabet is A-Z then space . , - ' ?
  function automatic sym_t sym_map(input logic [7:0] b);
    sym_t s;
    s.known = 1'b1;
    s.idx   = '0;
    case (b) inside
      [8'h41:8'h5A]: s.idx = SYM_BITS'(b - 8'h41);
      8'h20:         s.idx = 5'd26;  // space
      8'h2E:         s.idx = 5'd27;  // period
      8'h2C:         s.idx = 5'd28;  // comma
      8'h2D:         s.idx = 5'd29;  // dash
      8'h27:         s.idx = 5'd30;  // apostrophe
      8'h3F:         s.idx = 5'd31;  // question mark
      default:       s.known = 1'b0;
    endcase
    return s;
  endfunction

  // Exact match of (bits, length) against the code table.
  function automatic dec_res_t code_match(input logic [CODE_W-1:0] bits,
                                          input logic [3:0] len);
    dec_res_t r;
    r = '0;
    for (int i = 0; i < CODE_N; i++) begin
      if (CODE_TABLE[i].len == len && CODE_TABLE[i].value == bits) begin
        r.hit = 1'b1;
        r.ch  = r.ch | CODE_TABLE[i].ch;
      end
    end
    return r;
  endfunction

endpackage

FILE: src/pct_chan_if.sv
// Valid/ready channel carrying one payload struct per transaction.
// Depends on pct_pkg for the default payload type.
`timescale 1ns / 1ps

interface pct_chan_if #(
  parameter type payload_t = pct_pkg::in_item_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/pct_bit_dec.sv
// Bit-serial prefix decoder: pending buffer plus codeword match per bit.
// Depends on pct_pkg.
`timescale 1ns / 1ps

module pct_bit_dec (
  input  logic               clk,
  input  logic               rst_n,
  input  pct_pkg::dec_ctl_t  ctl,
  output pct_pkg::dec_res_t  res
);
  import pct_pkg::*;

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CODE_W-1:0] cand_bits;
  logic [3:0]        cand_len;

  // Buffer is zero above its count, so appending is a plain shift.
  assign cand_bits = {pend_r, ctl.bit_in};
  assign cand_len  = {1'b0, cnt_r} + 4'd1;
  assign res       = code_match(cand_bits, cand_len);

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (ctl.clear) begin
      pend_nxt = '0;
      cnt_nxt  = '0;
    end else if (ctl.step) begin
      if (res.hit || cand_len == 4'(CODE_W)) begin
        pend_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        pend_nxt = cand_bits[PEND_W-1:0];
        cnt_nxt  = cand_len[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: src/five_bit_to_prefix_code_transcoder_top.sv
// Top level of the prefix code transcoder: symbol shifter, sequencer, output staging.
// Depends on pct_pkg, pct_chan_if, pct_bit_dec and the assertion macro header.
//
//   channel | dir | payload fields                       | handshake
//   --------+-----+--------------------------------------+------------------
//   in_ch   | in  | char_in[7:0], char_valid, end_of_line | valid/ready
//   out_ch  | out | char_out[7:0], is_line_end, last      | valid/ready
//
// Sequence: accept; five bit steps for a mapped byte; a line-end step if end_of_line;
// then close. An idle item or unmapped byte without end_of_line is only accepted.
// The decoder consumes one code bit per cycle while the output does not stall.
// Reset: synchronous, active low; clears the sequencer, the staging slot, the
// output valid and the decoder's pending bits.
// Stalls: a bit step waits while the staging slot is full and out_ch is
// stalled; the input is taken only between items.
`timescale 1ns / 1ps
`include "five_bit_to_prefix_code_transcoder_top_assert.svh"

module five_bit_to_prefix_code_transcoder_top (
  input logic        clk,
  input logic        rst_n,
  pct_chan_if.sink   in_ch,
  pct_chan_if.source out_ch
);
  import pct_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EOL,
    ST_FLUSH
  } state_t;

  localparam logic [2:0] LAST_BIT = 3'(SYM_BITS - 1);

  state_t              state_r, state_nxt;
  logic [SYM_BITS-1:0] sreg_r, sreg_nxt;     // symbol bits, MSB leaves first
  logic [2:0]          bcnt_r, bcnt_nxt;     // bit position within symbol
  logic                eol_r, eol_nxt;
  // Staging slot: a result is held here until we know whether it is the last.
  logic                held_v_r, held_v_nxt;
  logic [7:0]          held_ch_r, held_ch_nxt;
  logic                held_le_r, held_le_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic                slot_free;
  logic                push;
  out_item_t           push_item;
  sym_t                sym;
  dec_ctl_t            dctl;
  dec_res_t            dres;

  pct_bit_dec u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .res   (dres)
  );

  assign sym            = sym_map(in_ch.payload.char_in);
  assign slot_free      = !out_valid_r || out_ch.ready;
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  always_comb begin
    state_nxt   = state_r;
    sreg_nxt    = sreg_r;
    bcnt_nxt    = bcnt_r;
    eol_nxt     = eol_r;
    held_v_nxt  = held_v_r;
    held_ch_nxt = held_ch_r;
    held_le_nxt = held_le_r;
    dctl        = '0;
    push        = 1'b0;
    push_item   = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          sreg_nxt = sym.idx;
          bcnt_nxt = '0;
          eol_nxt  = in_ch.payload.end_of_line;
          if (in_ch.payload.char_valid && sym.known) begin
            state_nxt = ST_SHIFT;
          end else if (in_ch.payload.end_of_line) begin
            state_nxt = ST_EOL;
          end
        end
      end
      ST_SHIFT: begin
        // A match with a result already staged must move it out first.
        if (slot_free || !held_v_r) begin
          dctl.step   = 1'b1;
          dctl.bit_in = sreg_r[SYM_BITS-1];
          sreg_nxt    = {sreg_r[SYM_BITS-2:0], 1'b0};
          bcnt_nxt    = bcnt_r + 3'd1;
          if (dres.hit) begin
            if (held_v_r) begin
              push                  = 1'b1;
              push_item.char_out    = held_ch_r;
              push_item.is_line_end = held_le_r;
            end
            held_v_nxt  = 1'b1;
            held_ch_nxt = dres.ch;
            held_le_nxt = 1'b0;
          end
          if (bcnt_r == LAST_BIT) begin
            state_nxt = eol_r ? ST_EOL : ST_FLUSH;
          end
        end
      end
      ST_EOL: begin
        if (slot_free || !held_v_r) begin
          dctl.clear = 1'b1;
          if (held_v_r) begin
            push                  = 1'b1;
            push_item.char_out    = held_ch_r;
            push_item.is_line_end = held_le_r;
          end
          held_v_nxt  = 1'b1;
          held_ch_nxt = '0;
          held_le_nxt = 1'b1;
          state_nxt   = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // Whatever is still staged is the item's final result.
        if (!held_v_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          push                  = 1'b1;
          push_item.char_out    = held_ch_r;
          push_item.is_line_end = held_le_r;
          push_item.last        = 1'b1;
          held_v_nxt            = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_item;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
      sreg_r      <= sreg_nxt;
      bcnt_r      <= bcnt_nxt;
      eol_r       <= eol_nxt;
      held_ch_r   <= held_ch_nxt;
      held_le_r   <= held_le_nxt;
      out_r       <= out_nxt;
    end
  end

  `PCT_ASSERT_NOW(a_idle_slot_empty, state_r == ST_IDLE, !held_v_r,
                  "staged result left over between transactions")
  `PCT_ASSERT_NOW(a_no_overwrite, push && out_valid_r, out_ch.ready,
                  "output register overwritten while stalled")
  `PCT_ASSERT_NOW(a_marker_zero, out_valid_r && out_r.is_line_end,
                  out_r.char_out == 8'd0, "line-end marker carries a character")
  `PCT_ASSERT_NOW(a_bit_range, state_r == ST_SHIFT, bcnt_r <= LAST_BIT,
                  "bit position past end of symbol")
  `PCT_ASSERT_NEXT(a_known_shifts,
                   state_r == ST_IDLE && in_ch.valid && in_ch.payload.char_valid
                   && sym.known, state_r == ST_SHIFT,
                   "mapped byte did not start shifting")

endmodule
